@@ hdl/skset_pkg.sv @@
// Package for the sorted key set: item structs, command codes, FSM states
// and the control bundle sent to every cell. No dependencies.
package skset_pkg;

  localparam int KEY_W   = 16;
  localparam int COUNT_W = 9;
  // Width of a presence group reduced in the compare cycle.
  localparam int GRP     = 16;

  localparam logic [1:0] CMD_QUERY  = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_DELETE = 2'd2;

  typedef struct packed {
    logic [1:0]       command;
    logic [KEY_W-1:0] key;
  } skset_req_t;

  typedef struct packed {
    logic               success;
    logic               set_full;
    logic [COUNT_W-1:0] entry_count;
  } skset_rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD
  } skset_state_t;

  typedef struct packed {
    logic capture;    // latch this cell's compare result
    logic shift_in;   // insert: open a slot at the insert position
    logic shift_out;  // delete: close the slot at the delete position
  } skset_cell_ctl_t;

endpackage

@@ hdl/skset_cell.sv @@
// One slot of the sorted key chain: holds a key, compares it with the probe
// key and shifts from either neighbor. Depends on skset_pkg.
module skset_cell
  import skset_pkg::*;
#(
  parameter int INDEX = 0,
  parameter int CNT_W = 9
) (
  input  logic             clk,
  input  skset_cell_ctl_t  ctl,
  input  logic [KEY_W-1:0] probe,
  input  logic [CNT_W-1:0] count,
  input  logic             left_lt,
  input  logic [KEY_W-1:0] left_key,
  input  logic [KEY_W-1:0] right_key,
  output logic [KEY_W-1:0] key,
  output logic             lt,
  output logic             eq
);

  logic occupied;
  logic lt_now;

  always_comb begin
    occupied = CNT_W'(INDEX) < count;
    lt_now   = occupied && (key < probe);
    eq       = occupied && (key == probe);
  end

  // Cells at or above the operation's position move; those below it stay.
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      lt <= lt_now;
    end
    if (ctl.shift_in && !lt) begin
      key <= left_lt ? probe : left_key;
    end else if (ctl.shift_out && !lt) begin
      key <= right_key;
    end
  end

endmodule

@@ hdl/sorted_key_set_core.sv @@
// Top level of the sorted key set: control FSM, presence reduction, result
// register and the chain of skset_cell slots. Depends on skset_pkg.
//
// Usage: a request item (command, key) enters on req_valid/req_ready; one
// response item (success, set_full, entry_count) leaves on
// rsp_valid/rsp_ready for every request, in order.
// After acceptance each request passes through a compare cycle, in which
// every cell compares its key with the probe and groups of sixteen presence
// flags are reduced into registers, and an update cycle, in which the chain
// shifts one slot for an insert or delete and the response is registered.
// A new request is taken in the update cycle of the previous one.
// If the receiver stalls, one response waits in the output register while
// the next request is compared; its update then holds until the waiting
// response is taken.
// Reset (rst, synchronous) empties the set and drops any pending response;
// slot contents are not cleared, only the count.
module sorted_key_set_core
  import skset_pkg::*;
#(
  parameter int CAPACITY = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_ready,
  input  skset_req_t req,
  output logic       rsp_valid,
  input  logic       rsp_ready,
  output skset_rsp_t rsp
);

  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int GROUPS = (CAPACITY + GRP - 1) / GRP;

  skset_state_t      state, state_next;
  skset_cell_ctl_t   ctl;
  logic              req_fire;
  logic              commit;

  logic [1:0]        op_cmd;
  logic [KEY_W-1:0]  op_key;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic [31:0]       count_ext;

  logic [KEY_W-1:0]  cell_key [CAPACITY];
  logic [CAPACITY-1:0] lt_vec;
  logic [CAPACITY-1:0] eq_vec;
  logic [GROUPS*GRP-1:0] eq_pad;
  logic [GROUPS-1:0] grp_hit;

  logic present;
  logic full;
  logic ins_go;
  logic del_go;
  logic success;
  logic refused;

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (req_valid) state_next = ST_CMP;
      ST_CMP:  state_next = ST_UPD;
      ST_UPD: begin
        if (commit) begin
          state_next = req_valid ? ST_CMP : ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Output logic.
  always_comb begin
    commit    = (state == ST_UPD) && (!rsp_valid || rsp_ready);
    req_ready = (state == ST_IDLE) || commit;
    req_fire  = req_valid && req_ready;
    ctl.capture   = (state == ST_CMP);
    ctl.shift_in  = commit && ins_go;
    ctl.shift_out = commit && del_go;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      op_cmd <= req.command;
      op_key <= req.key;
    end
  end

  // Presence is reduced in groups during the compare cycle.
  always_comb begin
    eq_pad = '0;
    eq_pad[CAPACITY-1:0] = eq_vec;
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      for (int g = 0; g < GROUPS; g++) begin
        grp_hit[g] <= |eq_pad[g*GRP +: GRP];
      end
    end
  end

  always_comb begin
    present = |grp_hit;
    full    = (count == CNT_W'(CAPACITY));
    ins_go  = (op_cmd == CMD_INSERT) && !present && !full;
    del_go  = (op_cmd == CMD_DELETE) && present;
    refused = (op_cmd == CMD_INSERT) && !present && full;
    case (op_cmd)
      CMD_QUERY:  success = present;
      CMD_INSERT: success = ins_go;
      CMD_DELETE: success = del_go;
      default:    success = 1'b0;
    endcase
    if (ins_go) begin
      count_next = count + CNT_W'(1);
    end else if (del_go) begin
      count_next = count - CNT_W'(1);
    end else begin
      count_next = count;
    end
    count_ext = 32'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (commit) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (commit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      rsp.success     <= success;
      rsp.set_full    <= refused;
      rsp.entry_count <= count_ext[COUNT_W-1:0];
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic             left_lt;
    logic [KEY_W-1:0] left_key;
    logic [KEY_W-1:0] right_key;

    if (i == 0) begin : g_first
      assign left_lt  = 1'b1;
      assign left_key = op_key;
    end else begin : g_mid
      assign left_lt  = lt_vec[i-1];
      assign left_key = cell_key[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_key = cell_key[i];
    end else begin : g_inner
      assign right_key = cell_key[i+1];
    end

    skset_cell #(
      .INDEX (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .probe     (op_key),
      .count     (count),
      .left_lt   (left_lt),
      .left_key  (left_key),
      .right_key (right_key),
      .key       (cell_key[i]),
      .lt        (lt_vec[i]),
      .eq        (eq_vec[i])
    );
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_rsp_from_commit: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(commit))
    else $error("response raised without an update cycle");

  a_delete_count: assert property (@(posedge clk) disable iff (rst)
    commit && del_go |=> count == $past(count) - CNT_W'(1))
    else $error("delete did not shrink the set by one");

  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    commit && ins_go |=> count == $past(count) + CNT_W'(1))
    else $error("insert did not grow the set by one");

endmodule

@@ tb/sorted_key_set_core_test.sv @@
// Self-checking testbench for sorted_key_set_core: a directed table, then random
// fill, full and drain traffic; results checked against typed rows or a queue-based set.
// Depends on skset_pkg and sorted_key_set_core.
module sorted_key_set_core_test;
  import skset_pkg::*;

  localparam int SET_CAPACITY = 256;
  localparam int RANDOM_ITEMS = 1700;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    LOAD_FILL,
    LOAD_FULL,
    LOAD_DRAIN
  } load_phase_t;

  typedef struct {
    skset_req_t op;
    bit         typed;
    skset_rsp_t rsp;
  } op_row_t;

  logic       clk;
  logic       rst;
  logic       req_valid;
  logic       req_ready;
  skset_req_t req;
  logic       rsp_valid;
  logic       rsp_ready;
  skset_rsp_t rsp;

  logic [KEY_W-1:0] held_keys[$];
  skset_rsp_t       pending_rsps[$];
  load_phase_t      load_phase;
  int               full_items_left;
  int               req_idle_pct;
  int               rsp_idle_pct;
  int               mismatches;
  int               items_sent;
  int               results_checked;
  int               full_refusals;
  int               peak_count;

  // Rows with typed = 1 carry an expectation read straight off the behavior;
  // the others take the predicted result.
  op_row_t directed_ops[] = '{
    '{'{CMD_QUERY,  16'h0000}, 1'b1, '{1'b0, 1'b0, 9'd0}},
    '{'{CMD_DELETE, 16'h0000}, 1'b1, '{1'b0, 1'b0, 9'd0}},
    '{'{CMD_UNUSED, 16'hFFFF}, 1'b1, '{1'b0, 1'b0, 9'd0}},
    '{'{CMD_INSERT, 16'h0000}, 1'b1, '{1'b1, 1'b0, 9'd1}},
    '{'{CMD_INSERT, 16'hFFFF}, 1'b1, '{1'b1, 1'b0, 9'd2}},
    '{'{CMD_INSERT, 16'h0000}, 1'b1, '{1'b0, 1'b0, 9'd2}},
    '{'{CMD_QUERY,  16'hFFFF}, 1'b1, '{1'b1, 1'b0, 9'd2}},
    '{'{CMD_QUERY,  16'hFFFE}, 1'b1, '{1'b0, 1'b0, 9'd2}},
    '{'{CMD_INSERT, 16'h8000}, 1'b0, '0},
    '{'{CMD_INSERT, 16'h7FFF}, 1'b0, '0},
    '{'{CMD_INSERT, 16'h0001}, 1'b0, '0},
    '{'{CMD_INSERT, 16'hAAAA}, 1'b0, '0},
    '{'{CMD_INSERT, 16'h5555}, 1'b0, '0},
    '{'{CMD_QUERY,  16'h7FFF}, 1'b0, '0},
    '{'{CMD_QUERY,  16'h8000}, 1'b0, '0},
    '{'{CMD_UNUSED, 16'h0000}, 1'b0, '0},
    '{'{CMD_DELETE, 16'h8000}, 1'b0, '0},
    '{'{CMD_DELETE, 16'h8000}, 1'b0, '0},
    '{'{CMD_DELETE, 16'h0000}, 1'b0, '0},
    '{'{CMD_DELETE, 16'hFFFF}, 1'b0, '0},
    '{'{CMD_QUERY,  16'h0000}, 1'b0, '0},
    '{'{CMD_INSERT, 16'hFFFE}, 1'b0, '0},
    '{'{CMD_INSERT, 16'h5554}, 1'b0, '0},
    '{'{CMD_DELETE, 16'h0001}, 1'b0, '0}
  };

  sorted_key_set_core #(
    .CAPACITY(SET_CAPACITY)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Applies one operation to the held set and returns the result it yields.
  function automatic skset_rsp_t apply_set_op(input skset_req_t op);
    skset_rsp_t r;
    int pos;
    bit present;
    r = '0;
    pos = 0;
    while (pos < held_keys.size() && held_keys[pos] < op.key) pos++;
    present = (pos < held_keys.size()) && (held_keys[pos] == op.key);
    case (op.command)
      CMD_QUERY: begin
        r.success = present;
      end
      CMD_INSERT: begin
        if (!present) begin
          if (held_keys.size() >= SET_CAPACITY) begin
            r.set_full = 1'b1;
          end else begin
            held_keys.insert(pos, op.key);
            r.success = 1'b1;
          end
        end
      end
      CMD_DELETE: begin
        if (present) begin
          held_keys.delete(pos);
          r.success = 1'b1;
        end
      end
      default: begin
      end
    endcase
    r.entry_count = COUNT_W'(held_keys.size());
    return r;
  endfunction

  // Picks a held key with the given odds, else an extreme or a random key.
  function automatic logic [KEY_W-1:0] choose_key(input int held_pct);
    int roll;
    roll = $urandom_range(99);
    if (held_keys.size() != 0 && roll < held_pct)
      return held_keys[$urandom_range(held_keys.size() - 1)];
    roll = $urandom_range(99);
    if (roll < 4) return '0;
    if (roll < 8) return '1;
    return KEY_W'($urandom);
  endfunction

  function automatic skset_req_t pick_random_op();
    skset_req_t op;
    int roll;
    roll = $urandom_range(99);
    case (load_phase)
      LOAD_FILL: begin
        if (roll < 80)      op = '{CMD_INSERT, choose_key(10)};
        else if (roll < 86) op = '{CMD_QUERY, choose_key(50)};
        else if (roll < 94) op = '{CMD_DELETE, choose_key(40)};
        else                op = '{CMD_UNUSED, choose_key(30)};
      end
      LOAD_FULL: begin
        // Mostly absent keys, so most inserts are refused for lack of room.
        if (roll < 55)      op = '{CMD_INSERT, choose_key(0)};
        else if (roll < 70) op = '{CMD_INSERT, choose_key(100)};
        else if (roll < 85) op = '{CMD_QUERY, choose_key(50)};
        else if (roll < 95) op = '{CMD_DELETE, choose_key(90)};
        else                op = '{CMD_UNUSED, choose_key(30)};
      end
      default: begin
        if (roll < 80)      op = '{CMD_DELETE, choose_key(90)};
        else if (roll < 86) op = '{CMD_QUERY, choose_key(50)};
        else if (roll < 94) op = '{CMD_INSERT, choose_key(20)};
        else                op = '{CMD_UNUSED, choose_key(30)};
      end
    endcase
    return op;
  endfunction

  // Entered at a falling edge; returns at the falling edge after acceptance,
  // leaving valid high so that a following item does not drop it.
  task automatic send_op(input skset_req_t op, input bit typed, input skset_rsp_t typed_rsp);
    skset_rsp_t predicted;
    while ($urandom_range(99) < req_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req <= op;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    predicted = apply_set_op(op);
    if (predicted.set_full) full_refusals++;
    if (held_keys.size() > peak_count) peak_count = held_keys.size();
    pending_rsps.push_back(typed ? typed_rsp : predicted);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic check_rsp(input skset_rsp_t want, input skset_rsp_t got);
    if (got.success !== want.success) begin
      $error("success: expected %0d, got %0d", want.success, got.success);
      mismatches++;
    end
    if (got.set_full !== want.set_full) begin
      $error("set_full: expected %0d, got %0d", want.set_full, got.set_full);
      mismatches++;
    end
    if (got.entry_count !== want.entry_count) begin
      $error("entry_count: expected %0d, got %0d", want.entry_count, got.entry_count);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    skset_rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_rsps.size() == 0) begin
        $error("result item with none expected: success %0d set_full %0d entry_count %0d",
               rsp.success, rsp.set_full, rsp.entry_count);
        mismatches++;
      end else begin
        want = pending_rsps.pop_front();
        check_rsp(want, rsp);
        results_checked++;
      end
    end
  end

  initial begin
    rsp_ready <= 1'b0;
    forever begin
      @(negedge clk);
      rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
    end
  end

  initial begin
    #(12 * 200000);
    $display("Run timed out with %0d results outstanding.", pending_rsps.size());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    mismatches = 0;
    items_sent = 0;
    results_checked = 0;
    full_refusals = 0;
    peak_count = 0;
    load_phase = LOAD_FILL;
    full_items_left = 0;
    req_idle_pct = 21;
    rsp_idle_pct = 83;
    rst <= 1'b1;
    req_valid <= 1'b0;
    req <= '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_ops[i])
      send_op(directed_ops[i].op, directed_ops[i].typed, directed_ops[i].rsp);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) begin
        req_idle_pct = 83;
        rsp_idle_pct = 21;
      end else if (n == 2 * RANDOM_ITEMS / 3) begin
        req_idle_pct = 0;
        rsp_idle_pct = 0;
      end
      send_op(pick_random_op(), 1'b0, '0);
      // The traffic mix follows the set's size: fill it, hold it full, drain it.
      case (load_phase)
        LOAD_FILL: begin
          if (held_keys.size() >= SET_CAPACITY) begin
            load_phase = LOAD_FULL;
            full_items_left = 40;
          end
        end
        LOAD_FULL: begin
          full_items_left--;
          if (full_items_left == 0) load_phase = LOAD_DRAIN;
        end
        default: begin
          if (held_keys.size() <= 1) load_phase = LOAD_FILL;
        end
      endcase
    end
    req_valid <= 1'b0;

    while (pending_rsps.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d items and checked %0d results; peak count %0d, %0d inserts refused as full.",
             items_sent, results_checked, peak_count, full_refusals);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
